FILE: hw/rtl/rae_pkg.sv
`timescale 1ns / 1ps

package rae_pkg;

    // Storage sizes.
    localparam int REG_COUNT  = 32;
    localparam int DATA_WORDS = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int MEM_IDX_W  = $clog2(DATA_WORDS);
    localparam int WORD_W     = 32;

    // Register field positions inside the instruction word.
    localparam int FIELD_A_LSB = 21;
    localparam int FIELD_B_LSB = 16;
    localparam int FIELD_C_LSB = 11;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        OP_NOP = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_DIV = 4'd4,
        OP_MOD = 4'd5,
        OP_AND = 4'd6,
        OP_OR  = 4'd7,
        OP_XOR = 4'd8,
        OP_CMP = 4'd9,
        OP_LDA = 4'd10,
        OP_STA = 4'd11,
        OP_MOV = 4'd12
    } op_t;

    // Compare results.
    localparam logic [WORD_W-1:0] CMP_EQUAL = WORD_W'(0);
    localparam logic [WORD_W-1:0] CMP_LESS  = WORD_W'(1);
    localparam logic [WORD_W-1:0] CMP_MORE  = WORD_W'(2);

    typedef struct packed {
        logic [3:0]        req_type;
        logic [WORD_W-1:0] instr_word;
    } req_t;

    typedef struct packed {
        logic                 reg_written;
        logic [REG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    reg_value;
        logic                 mem_written;
        logic [MEM_IDX_W-1:0] mem_index;
        logic [WORD_W-1:0]    mem_value;
        logic                 div_zero;
    } rsp_t;

    // Decoded operation handed from the front to the back.
    typedef struct packed {
        op_t                  op;
        logic [REG_IDX_W-1:0] fa;
        logic [REG_IDX_W-1:0] fb;
        logic [REG_IDX_W-1:0] fc;
    } uop_t;

endpackage

FILE: hw/rtl/rae_front.sv
`timescale 1ns / 1ps

module rae_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rae_pkg::req_t req,
    output logic          uop_valid,
    input  logic          uop_ready,
    output rae_pkg::uop_t uop
);

    logic          stg_valid_reg;
    logic          stg_valid_next;
    rae_pkg::uop_t stg_uop_reg;
    rae_pkg::uop_t dec_uop;
    logic          req_fire;

    // Unused operation codes decode to a no-op.
    always_comb
    begin
        dec_uop.fa = req.instr_word[rae_pkg::FIELD_A_LSB +: rae_pkg::REG_IDX_W];
        dec_uop.fb = req.instr_word[rae_pkg::FIELD_B_LSB +: rae_pkg::REG_IDX_W];
        dec_uop.fc = req.instr_word[rae_pkg::FIELD_C_LSB +: rae_pkg::REG_IDX_W];
        case (rae_pkg::op_t'(req.req_type))
            rae_pkg::OP_ADD, rae_pkg::OP_SUB, rae_pkg::OP_MUL, rae_pkg::OP_DIV,
            rae_pkg::OP_MOD, rae_pkg::OP_AND, rae_pkg::OP_OR,  rae_pkg::OP_XOR,
            rae_pkg::OP_CMP, rae_pkg::OP_LDA, rae_pkg::OP_STA, rae_pkg::OP_MOV:
                dec_uop.op = rae_pkg::op_t'(req.req_type);
            default:
                dec_uop.op = rae_pkg::OP_NOP;
        endcase
    end

    assign req_ready      = !stg_valid_reg || uop_ready;
    assign req_fire       = req_valid && req_ready;
    assign stg_valid_next = req_fire || (stg_valid_reg && !uop_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stg_uop_reg <= dec_uop;
        end
    end

    assign uop_valid = stg_valid_reg;
    assign uop       = stg_uop_reg;

endmodule

FILE: hw/rtl/rae_queue.sv
`timescale 1ns / 1ps

module rae_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rae_pkg::uop_t push_uop,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rae_pkg::uop_t pop_uop
);

    rae_pkg::uop_t                      entry_reg [rae_pkg::QUEUE_DEPTH];
    logic [rae_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [rae_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [rae_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [rae_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [rae_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [rae_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               push_fire;
    logic                               pop_fire;

    assign push_ready = (count_reg != rae_pkg::QUEUE_CNT_W'(rae_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_uop    = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == rae_pkg::QUEUE_PTR_W'(rae_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == rae_pkg::QUEUE_PTR_W'(rae_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_uop;
        end
    end

endmodule

FILE: hw/rtl/rae_back.sv
`timescale 1ns / 1ps

module rae_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          uop_valid,
    output logic          uop_ready,
    input  rae_pkg::uop_t uop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rae_pkg::rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_WB   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Register file and data store. Entries never written since reset read
    // as zero through the valid bits.
    logic [rae_pkg::WORD_W-1:0] rf_mem [rae_pkg::REG_COUNT];
    logic [rae_pkg::WORD_W-1:0] ds_mem [rae_pkg::DATA_WORDS];
    logic [rae_pkg::REG_COUNT-1:0]  rf_vld_reg;
    logic [rae_pkg::DATA_WORDS-1:0] ds_vld_reg;

    rae_pkg::uop_t              op_reg;
    logic [rae_pkg::WORD_W-1:0] a_data_reg;
    logic [rae_pkg::WORD_W-1:0] b_data_reg;
    logic [rae_pkg::WORD_W-1:0] ds_data_reg;
    logic                       a_vld_reg;
    logic                       b_vld_reg;
    logic                       ds_vld_rd_reg;
    logic [rae_pkg::WORD_W-1:0] va;
    logic [rae_pkg::WORD_W-1:0] vb;
    logic [rae_pkg::WORD_W-1:0] vd;

    rae_pkg::rsp_t res_reg;
    rae_pkg::rsp_t res_next;
    rae_pkg::rsp_t out_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          start_div;

    // Restoring divider state.
    logic [rae_pkg::WORD_W-1:0]    quo_reg;
    logic [rae_pkg::WORD_W-1:0]    rem_reg;
    logic [rae_pkg::WORD_W-1:0]    dvs_reg;
    logic [rae_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [rae_pkg::WORD_W:0]      div_shift;
    logic [rae_pkg::WORD_W:0]      div_diff;
    logic [rae_pkg::WORD_W-1:0]    quo_step;
    logic [rae_pkg::WORD_W-1:0]    rem_step;
    logic                          div_last;

    logic pop_fire;
    logic wb_fire;

    assign uop_ready = (state_reg == ST_IDLE);
    assign pop_fire  = uop_valid && uop_ready;
    assign wb_fire   = (state_reg == ST_WB) && (!out_valid_reg || rsp_ready);

    assign va = a_vld_reg     ? a_data_reg  : '0;
    assign vb = b_vld_reg     ? b_data_reg  : '0;
    assign vd = ds_vld_rd_reg ? ds_data_reg : '0;

    // One quotient bit per cycle; the remainder stays below the divisor, so
    // the shifted value fits in one extra bit.
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[rae_pkg::WORD_W-1]};
        div_diff  = div_shift - {1'b0, dvs_reg};
        if (!div_diff[rae_pkg::WORD_W])
        begin
            rem_step = div_diff[rae_pkg::WORD_W-1:0];
            quo_step = {quo_reg[rae_pkg::WORD_W-2:0], 1'b1};
        end
        else
        begin
            rem_step = div_shift[rae_pkg::WORD_W-1:0];
            quo_step = {quo_reg[rae_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign div_last = (div_cnt_reg == rae_pkg::DIV_CNT_W'(rae_pkg::DIV_STEPS - 1));

    // Result of everything except a divide or modulo that goes to the iterative unit.
    always_comb
    begin
        res_next  = '0;
        start_div = 1'b0;
        case (op_reg.op)
            rae_pkg::OP_ADD:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va + vb;
            end
            rae_pkg::OP_SUB:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va - vb;
            end
            rae_pkg::OP_MUL:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va * vb;
            end
            rae_pkg::OP_DIV, rae_pkg::OP_MOD:
            begin
                if (vb == '0)
                begin
                    res_next.div_zero = 1'b1;
                end
                else
                begin
                    start_div = 1'b1;
                end
            end
            rae_pkg::OP_AND:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va & vb;
            end
            rae_pkg::OP_OR:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va | vb;
            end
            rae_pkg::OP_XOR:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                res_next.reg_value   = va ^ vb;
            end
            rae_pkg::OP_CMP:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fc;
                if (va == vb)
                begin
                    res_next.reg_value = rae_pkg::CMP_EQUAL;
                end
                else if (va < vb)
                begin
                    res_next.reg_value = rae_pkg::CMP_LESS;
                end
                else
                begin
                    res_next.reg_value = rae_pkg::CMP_MORE;
                end
            end
            rae_pkg::OP_LDA:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fb;
                res_next.reg_value   = vd;
            end
            rae_pkg::OP_STA:
            begin
                res_next.mem_written = 1'b1;
                res_next.mem_index   = op_reg.fb;
                res_next.mem_value   = va;
            end
            rae_pkg::OP_MOV:
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = op_reg.fb;
                res_next.reg_value   = rae_pkg::WORD_W'(op_reg.fa);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = start_div ? ST_DIV : ST_WB;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (wb_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = wb_fire || (out_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
            ds_vld_reg    <= '0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            ds_vld_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop_fire)
            begin
                a_vld_reg     <= rf_vld_reg[uop.fa];
                b_vld_reg     <= rf_vld_reg[uop.fb];
                ds_vld_rd_reg <= ds_vld_reg[uop.fa];
            end
            if (wb_fire && res_reg.reg_written)
            begin
                rf_vld_reg[res_reg.reg_index] <= 1'b1;
            end
            if (wb_fire && res_reg.mem_written)
            begin
                ds_vld_reg[res_reg.mem_index] <= 1'b1;
            end
        end
    end

    // Storage and datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            op_reg      <= uop;
            a_data_reg  <= rf_mem[uop.fa];
            b_data_reg  <= rf_mem[uop.fb];
            ds_data_reg <= ds_mem[uop.fa];
        end
        if (wb_fire && res_reg.reg_written)
        begin
            rf_mem[res_reg.reg_index] <= res_reg.reg_value;
        end
        if (wb_fire && res_reg.mem_written)
        begin
            ds_mem[res_reg.mem_index] <= res_reg.mem_value;
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg     <= res_next;
            quo_reg     <= va;
            rem_reg     <= '0;
            dvs_reg     <= vb;
            div_cnt_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            quo_reg     <= quo_step;
            rem_reg     <= rem_step;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_last)
            begin
                res_reg.reg_written <= 1'b1;
                res_reg.reg_index   <= op_reg.fc;
                res_reg.reg_value   <= (op_reg.op == rae_pkg::OP_DIV) ? quo_step : rem_step;
            end
        end
        if (wb_fire)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: hw/rtl/register_alu_execute_unit_core.sv
`timescale 1ns / 1ps
// A request passes the front stage register and the queue; the back then reads its operands,
// executes the instruction, writes back and loads the output register that drives rsp_valid.
// The back sequencer takes a new instruction only after the last one is written back; div and
// mod with a nonzero divisor run in its divider, which forms one quotient bit per cycle.
// Reset: rst_n is asynchronous and active low. It empties the front stage, the queue and the
// output register, and clears the valid bits so the register file and data store read as zero.

module register_alu_execute_unit_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rae_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rae_pkg::rsp_t rsp
);

    // The front decodes the operation code and the register fields of each
    // request and holds the decoded instruction in one stage register.
    logic          front_valid;
    logic          front_ready;
    rae_pkg::uop_t front_uop;

    // The queue lets the front take new requests while the back is busy
    // with a long divide.
    logic          back_valid;
    logic          back_ready;
    rae_pkg::uop_t back_uop;

    rae_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .uop_valid (front_valid),
        .uop_ready (front_ready),
        .uop       (front_uop)
    );

    rae_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_uop   (front_uop),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_uop    (back_uop)
    );

    // The back reads the register file and data store, executes the
    // instruction, writes the state back and places the result in an output
    // register, which can hold it while the back fetches the next
    // instruction.
    rae_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (back_valid),
        .uop_ready (back_ready),
        .uop       (back_uop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
